// File: rtl/bac_pkg.sv
// Package for the BCD alarm clock controller: item structs, mode, field,
// operation and key codes, and the fixed constants of the block.
// No dependencies; every other file of the block imports it.
package bac_pkg;

  typedef enum logic [1:0] {
    OP_CLOCK = 2'd0,
    OP_TICK  = 2'd1,
    OP_KEY   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KEY_TIME  = 2'd0,
    KEY_ALARM = 2'd1,
    KEY_UP    = 2'd2,
    KEY_DOWN  = 2'd3
  } key_e;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_SET_TIME  = 2'd1,
    MODE_SET_ALARM = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    FIELD_NONE = 2'd0,
    FIELD_HOUR = 2'd1,
    FIELD_MIN  = 2'd2,
    FIELD_SEC  = 2'd3
  } field_e;

  // Reset value of the alarm duration register, in alarm ticks.
  localparam logic [7:0] DURATION_RESET = 8'd25;

  // Wrap points of the BCD fields.
  localparam logic [6:0] HOUR_MAX   = 7'h23;
  localparam logic [6:0] MINSEC_MAX = 7'h59;

  typedef struct packed {
    logic [5:0] hour;
    logic [6:0] min;
    logic [6:0] sec;
  } hms_t;

  typedef struct packed {
    op_e        op;
    key_e       key;
    logic [5:0] now_hour;
    logic [6:0] now_min;
    logic [6:0] now_sec;
  } in_item_t;

  typedef struct packed {
    mode_e      mode;
    field_e     field_index;
    logic [5:0] show_hour;
    logic [6:0] show_min;
    logic [6:0] show_sec;
    logic       led_on;
    logic       alarm_ringing;
    logic       muted;
    logic       write_clock;
    logic       reload_clock;
  } out_item_t;

endpackage

// File: rtl/bcd_alarm_clock_controller_core.sv
// Top level of the BCD alarm clock controller: input stage, alarm duration
// register and result register around bac_core. Uses bac_pkg.
//
// Usage: items enter on the in_valid_i / in_ready_o channel. Each item is a
// clock update, an alarm tick or a key press, and every accepted item gives
// exactly one result item on out_valid_o / out_ready_i, in order. The result
// carries the mode, the edited field, the time or alarm to show, the LED,
// ringing and mute flags, and one-item pulses asking the host to write or
// reread its clock source.
//
// An accepted item sits in the input register while the controller state
// is updated, and its result is then held in the result register. The
// block takes one item per cycle while the receiver does not stall, since
// all work for an item is one short pass of logic between the two registers.
//
// When the receiver stalls, the result register holds its item and the
// input register keeps one more; in_ready_o drops only when both are full.
//
// The alarm duration register is written with cfg_we_i and cfg_data_i and
// should only change while no item is in flight. Reset returns it to 25
// ticks, clears all controller state to normal mode at 00:00:00 with the
// alarm at 00:00:00, and empties both registers.
module bcd_alarm_clock_controller_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bac_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bac_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i
);
  import bac_pkg::*;

  logic       stage_valid_q, stage_valid_d;
  in_item_t   stage_item_q;
  logic       out_valid_q, out_valid_d;
  out_item_t  result_q;
  out_item_t  result_d;
  logic [7:0] duration_q;
  logic       stage_adv;
  logic       in_fire;

  // The staged item moves on whenever the result register is empty or its
  // item is taken in the same cycle.
  assign stage_adv  = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || stage_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign stage_valid_d = in_fire || (stage_valid_q && !stage_adv);
  assign out_valid_d   = stage_adv || (out_valid_q && !out_ready_i);

  // The core updates its state only on the edge that moves an item on.
  bac_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_en_i  (stage_adv),
    .item_i     (stage_item_q),
    .duration_i (duration_q),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      duration_q    <= DURATION_RESET;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        duration_q <= cfg_data_i;
      end
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_item_q <= in_data_i;
    end
    if (stage_adv) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = result_q;

  // An item that leaves the input stage must show up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) stage_adv |=> out_valid_q)
    else $error("advanced item did not reach the result register");

  // Clock write and reload requests are only raised on leaving a set mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.write_clock || result_q.reload_clock)
    |-> result_q.mode == MODE_NORMAL)
    else $error("clock pulse outside normal mode");

  // Both clock requests never come in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(result_q.write_clock && result_q.reload_clock))
    else $error("write and reload requested together");

endmodule

// File: rtl/bac_bcd_step.sv
// BCD field stepper: raises or lowers one BCD hour, minute or second value
// with wrap at 23 or 59. Uses the wrap constants of bac_pkg.
module bac_bcd_step (
  input  logic [6:0] value_i,
  input  logic       is_hour_i,
  input  logic       up_i,
  output logic [6:0] value_o
);
  import bac_pkg::*;

  logic [6:0] up_val;
  logic [6:0] down_val;
  logic [6:0] plus_one;
  logic [6:0] minus_one;

  assign plus_one  = value_i + 7'd1;
  assign minus_one = value_i - 7'd1;

  // Increment walks the same compare chain for valid and invalid codes,
  // so any value at or above the top of the range wraps to zero.
  always_comb begin
    if (value_i < 7'h09) begin
      up_val = plus_one;
    end else if (value_i == 7'h09) begin
      up_val = 7'h10;
    end else if (value_i < 7'h19) begin
      up_val = plus_one;
    end else if (value_i == 7'h19) begin
      up_val = 7'h20;
    end else if (is_hour_i) begin
      up_val = (value_i < HOUR_MAX) ? plus_one : 7'h00;
    end else if (value_i < 7'h29) begin
      up_val = plus_one;
    end else if (value_i == 7'h29) begin
      up_val = 7'h30;
    end else if (value_i < 7'h39) begin
      up_val = plus_one;
    end else if (value_i == 7'h39) begin
      up_val = 7'h40;
    end else if (value_i < 7'h49) begin
      up_val = plus_one;
    end else if (value_i == 7'h49) begin
      up_val = 7'h50;
    end else if (value_i < MINSEC_MAX) begin
      up_val = plus_one;
    end else begin
      up_val = 7'h00;
    end
  end

  // Decrement borrows across the tens digit and wraps zero to the top.
  always_comb begin
    if (!is_hour_i && value_i > 7'h50) begin
      down_val = minus_one;
    end else if (!is_hour_i && value_i == 7'h50) begin
      down_val = 7'h49;
    end else if (!is_hour_i && value_i > 7'h40) begin
      down_val = minus_one;
    end else if (!is_hour_i && value_i == 7'h40) begin
      down_val = 7'h39;
    end else if (!is_hour_i && value_i > 7'h30) begin
      down_val = minus_one;
    end else if (!is_hour_i && value_i == 7'h30) begin
      down_val = 7'h29;
    end else if (value_i > 7'h20) begin
      down_val = minus_one;
    end else if (value_i == 7'h20) begin
      down_val = 7'h19;
    end else if (value_i > 7'h10) begin
      down_val = minus_one;
    end else if (value_i == 7'h10) begin
      down_val = 7'h09;
    end else if (value_i > 7'h00) begin
      down_val = minus_one;
    end else begin
      down_val = is_hour_i ? HOUR_MAX : MINSEC_MAX;
    end
  end

  assign value_o = up_i ? up_val : down_val;

endmodule

// File: rtl/bac_core.sv
// Controller state and per-item update logic of the BCD alarm clock:
// mode state machine, time, alarm and ring bookkeeping. Uses bac_pkg and
// one bac_bcd_step instance.
module bac_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_en_i,
  input  bac_pkg::in_item_t  item_i,
  input  logic [7:0]         duration_i,
  output bac_pkg::out_item_t result_o
);
  import bac_pkg::*;

  mode_e      mode_q, mode_d;
  field_e     field_q, field_d;
  hms_t       time_q, time_d;
  hms_t       saved_q, saved_d;
  hms_t       alarm_q, alarm_d;
  logic       mute_q, mute_d;
  logic       ring_q, ring_d;
  logic       blink_q, blink_d;
  logic       led_q, led_d;
  logic [7:0] count_q, count_d;

  logic       wr_pulse;
  logic       rl_pulse;
  logic       silence_key;
  logic       alarm_match;
  logic [7:0] count_inc;
  hms_t       edit_hms;
  hms_t       show_hms;
  logic [6:0] step_in;
  logic [6:0] step_out;

  // A key while ringing in normal mode only silences the alarm.
  assign silence_key = (mode_q == MODE_NORMAL) && ring_q;
  assign alarm_match = (time_q == alarm_q);
  assign count_inc   = count_q + 8'd1;

  assign edit_hms = (mode_q == MODE_SET_TIME) ? time_q : alarm_q;

  always_comb begin
    case (field_q)
      FIELD_HOUR: step_in = {1'b0, edit_hms.hour};
      FIELD_MIN:  step_in = edit_hms.min;
      default:    step_in = edit_hms.sec;
    endcase
  end

  bac_bcd_step u_step (
    .value_i   (step_in),
    .is_hour_i (field_q == FIELD_HOUR),
    .up_i      (item_i.key == KEY_UP),
    .value_o   (step_out)
  );

  // Next mode.
  always_comb begin
    mode_d = mode_q;
    if (item_en_i && item_i.op == OP_KEY && !silence_key) begin
      unique case (mode_q)
        MODE_NORMAL: begin
          if (item_i.key == KEY_TIME) begin
            mode_d = MODE_SET_TIME;
          end else if (item_i.key == KEY_ALARM) begin
            mode_d = MODE_SET_ALARM;
          end
        end
        MODE_SET_TIME: begin
          if (item_i.key == KEY_TIME && field_q == FIELD_SEC) begin
            mode_d = MODE_NORMAL;
          end
        end
        MODE_SET_ALARM: begin
          if (item_i.key == KEY_ALARM && field_q == FIELD_SEC) begin
            mode_d = MODE_NORMAL;
          end
        end
        default: mode_d = mode_q;
      endcase
    end
  end

  // Field, time, alarm and ring state, plus the clock pulses.
  always_comb begin
    field_d  = field_q;
    time_d   = time_q;
    saved_d  = saved_q;
    alarm_d  = alarm_q;
    mute_d   = mute_q;
    ring_d   = ring_q;
    blink_d  = blink_q;
    led_d    = led_q;
    count_d  = count_q;
    wr_pulse = 1'b0;
    rl_pulse = 1'b0;
    if (item_en_i) begin
      case (item_i.op)
        OP_CLOCK: begin
          if (mode_q != MODE_SET_TIME) begin
            time_d = '{hour: item_i.now_hour, min: item_i.now_min, sec: item_i.now_sec};
          end
        end
        OP_TICK: begin
          if (ring_q || alarm_match) begin
            ring_d  = 1'b1;
            count_d = count_inc;
            if (!mute_q) begin
              blink_d = ~blink_q;
              led_d   = ~blink_q;
            end
            if (count_inc == duration_i) begin
              mute_d  = 1'b1;
              ring_d  = 1'b0;
              count_d = 8'd0;
              led_d   = 1'b0;
            end
          end
        end
        OP_KEY: begin
          if (silence_key) begin
            mute_d  = 1'b1;
            ring_d  = 1'b0;
            count_d = 8'd0;
            led_d   = 1'b0;
          end else if (item_i.key == KEY_TIME || item_i.key == KEY_ALARM) begin
            if (mode_q == MODE_NORMAL) begin
              field_d = FIELD_HOUR;
              if (item_i.key == KEY_TIME) begin
                saved_d = time_q;
              end
            end else if ((mode_q == MODE_SET_TIME && item_i.key == KEY_TIME) ||
                         (mode_q == MODE_SET_ALARM && item_i.key == KEY_ALARM)) begin
              if (field_q == FIELD_SEC) begin
                field_d = FIELD_NONE;
                if (item_i.key == KEY_TIME) begin
                  // Only a changed time is written back to the clock source.
                  if (saved_q == time_q) begin
                    rl_pulse = 1'b1;
                  end else begin
                    wr_pulse = 1'b1;
                  end
                end else begin
                  mute_d   = 1'b0;
                  rl_pulse = 1'b1;
                end
              end else if (field_q == FIELD_HOUR) begin
                field_d = FIELD_MIN;
              end else if (field_q == FIELD_MIN) begin
                field_d = FIELD_SEC;
              end else begin
                field_d = FIELD_HOUR;
              end
            end
          end else if ((mode_q == MODE_SET_TIME || mode_q == MODE_SET_ALARM) &&
                       field_q != FIELD_NONE) begin
            if (mode_q == MODE_SET_TIME) begin
              case (field_q)
                FIELD_HOUR: time_d.hour = step_out[5:0];
                FIELD_MIN:  time_d.min  = step_out;
                default:    time_d.sec  = step_out;
              endcase
            end else begin
              case (field_q)
                FIELD_HOUR: alarm_d.hour = step_out[5:0];
                FIELD_MIN:  alarm_d.min  = step_out;
                default:    alarm_d.sec  = step_out;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign show_hms = (mode_d == MODE_SET_ALARM) ? alarm_d : time_d;

  assign result_o = '{
    mode:          mode_d,
    field_index:   field_d,
    show_hour:     show_hms.hour,
    show_min:      show_hms.min,
    show_sec:      show_hms.sec,
    led_on:        led_d,
    alarm_ringing: ring_d,
    muted:         mute_d,
    write_clock:   wr_pulse,
    reload_clock:  rl_pulse
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      field_q <= FIELD_NONE;
      time_q  <= '0;
      saved_q <= '0;
      alarm_q <= '0;
      mute_q  <= 1'b0;
      ring_q  <= 1'b0;
      blink_q <= 1'b0;
      led_q   <= 1'b0;
      count_q <= 8'd0;
    end else begin
      mode_q  <= mode_d;
      field_q <= field_d;
      time_q  <= time_d;
      saved_q <= saved_d;
      alarm_q <= alarm_d;
      mute_q  <= mute_d;
      ring_q  <= ring_d;
      blink_q <= blink_d;
      led_q   <= led_d;
      count_q <= count_d;
    end
  end

  // An edited field exists exactly while a set mode is active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_NORMAL) == (field_q == FIELD_NONE))
    else $error("field index out of step with mode");

  // The LED can only be lit while the alarm rings.
  assert property (@(posedge clk_i) disable iff (!rst_ni) led_q |-> ring_q)
    else $error("LED lit without ringing alarm");

endmodule
